[sv/elc_pkg.sv]
// ----------------------------------------------------------------------------
// elc_pkg: shared constants, types and table functions
// Holds the fixed-point constants of the lune coordinate datapath, the
// arctangent table generator and the structs passed between the stages.
// ----------------------------------------------------------------------------
package elc_pkg;

    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam int          NORM_BITS      = 29;
    localparam int          ISQRT_STEPS    = 32;
    localparam int          CORDIC_STEPS   = 48;
    localparam int          CORDIC_PRESHIFT = 24;
    localparam logic [63:0] DEG_DEN        = PI_Q60 >> 14;
    localparam int          REM_W          = 49;
    localparam int          LAT_W          = 24;
    localparam int          LON_W          = 22;
    localparam int          OUT_TDATA_W    = 48;
    localparam int          LAT_LIMIT      = 90;
    localparam int          LON_LIMIT      = 30;

    typedef struct packed {
        logic [63:0]        rad_lat;
        logic [63:0]        rad_lon;
        logic signed [31:0] y_lat;
        logic signed [31:0] y_lon;
        logic               degenerate;
        logic               lon_zero;
    } t_geom;

    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic             degenerate;
    } t_result;

    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-idx) in radians with 48 fraction bits.
    function automatic logic [63:0] atan_q48(input int idx);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = '0;
        term = '0;
        if (idx == 0) begin
            return (PI_Q60 + 64'd8192) >> 14;
        end
        for (int k = 0; k < 32; k++) begin
            if (idx * (2 * k + 1) <= 62) begin
                term = long_div(64'd1 << (62 - idx * (2 * k + 1)), 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return (sum + 64'd8192) >> 14;
    endfunction

endpackage

[sv/eigenvalues_to_lune_coords.sv]
// ----------------------------------------------------------------------------
// eigenvalues_to_lune_coords: moment-tensor eigenvalues to lune angles
// Each input word carries three signed eigenvalues in any order, packed from
// the lowest bit up as eig_a, eig_b, eig_c. Each output word carries the
// lune latitude and longitude in degrees with ANGLE_FRAC_BITS fraction bits,
// and tuser flags an all-zero input, whose angles are then zero.
// The block is a single pipeline: sort and scaling, square roots, CORDIC
// arctangents and a degree divider, all one stage per step, with latitude and
// longitude computed side by side. One word is taken every cycle while
// tready is high. The length of the pipeline comes from the 32 root
// stages, the 48 CORDIC stages and one divider stage per quotient bit.
// Reset clears all valid bits; nothing else needs clearing. When the
// receiver stalls, the finished word waits in the output register and one
// more word is taken into a skid register, after which the whole pipeline
// holds and tready drops until the skid register drains.
// ----------------------------------------------------------------------------
module eigenvalues_to_lune_coords #(
    parameter int EIG_WIDTH       = 32,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // eig_a, eig_b, eig_c, zero padding
    input  logic [((3 * EIG_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // lune_latitude, lune_longitude, zero padding
    output logic [elc_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // degenerate
    output logic                                   o_m_axis_tuser
);

    localparam int DEG_W = ANGLE_FRAC_BITS + 10;

    logic ce;

    logic           fr_valid;
    elc_pkg::t_geom fr_geom;

    logic        sq_lat_valid, sq_lon_valid;
    logic [31:0] sq_lat_root, sq_lon_root;
    logic [32:0] sq_lat_tag, sq_lon_tag;

    logic        co_lat_valid, co_lon_valid;
    logic [63:0] co_lat_angle, co_lon_angle;
    logic        co_lat_neg, co_lon_neg;
    logic        co_lat_tag, co_lon_tag;

    logic                    dg_lat_valid, dg_lon_valid;
    logic signed [DEG_W-1:0] dg_lat_deg, dg_lon_deg;
    logic                    dg_lat_tag, dg_lon_tag;

    logic signed [63:0] lat_ext, lon_ext;
    elc_pkg::t_result   p_result;

    logic             r_out_valid, r_skid_valid;
    elc_pkg::t_result r_out, r_skid;

    assign ce              = !r_skid_valid;
    assign o_s_axis_tready = ce;

    elc_front #(
        .EIG_WIDTH(EIG_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_axis_tvalid),
        .i_eig_a (i_s_axis_tdata[EIG_WIDTH-1:0]),
        .i_eig_b (i_s_axis_tdata[2*EIG_WIDTH-1:EIG_WIDTH]),
        .i_eig_c (i_s_axis_tdata[3*EIG_WIDTH-1:2*EIG_WIDTH]),
        .o_valid (fr_valid),
        .o_geom  (fr_geom)
    );

    elc_isqrt #(.TAG_W(33)) u_isqrt_lat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (fr_valid),
        .i_radicand (fr_geom.rad_lat),
        .i_tag      ({fr_geom.degenerate, fr_geom.y_lat}),
        .o_valid    (sq_lat_valid),
        .o_root     (sq_lat_root),
        .o_tag      (sq_lat_tag)
    );

    elc_isqrt #(.TAG_W(33)) u_isqrt_lon (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (fr_valid),
        .i_radicand (fr_geom.rad_lon),
        .i_tag      ({fr_geom.lon_zero, fr_geom.y_lon}),
        .o_valid    (sq_lon_valid),
        .o_root     (sq_lon_root),
        .o_tag      (sq_lon_tag)
    );

    elc_cordic #(.TAG_W(1)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_lat_valid),
        .i_x     (sq_lat_root),
        .i_y     ($signed(sq_lat_tag[31:0])),
        .i_tag   (sq_lat_tag[32]),
        .o_valid (co_lat_valid),
        .o_angle (co_lat_angle),
        .o_neg   (co_lat_neg),
        .o_tag   (co_lat_tag)
    );

    elc_cordic #(.TAG_W(1)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_lon_valid),
        .i_x     (sq_lon_root),
        .i_y     ($signed(sq_lon_tag[31:0])),
        .i_tag   (sq_lon_tag[32]),
        .o_valid (co_lon_valid),
        .o_angle (co_lon_angle),
        .o_neg   (co_lon_neg),
        .o_tag   (co_lon_tag)
    );

    elc_degrees #(
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .LIMIT_DEG (elc_pkg::LAT_LIMIT),
        .TAG_W     (1)
    ) u_deg_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (co_lat_valid),
        .i_angle (co_lat_angle),
        .i_neg   (co_lat_neg),
        .i_tag   (co_lat_tag),
        .o_valid (dg_lat_valid),
        .o_deg   (dg_lat_deg),
        .o_tag   (dg_lat_tag)
    );

    elc_degrees #(
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .LIMIT_DEG (elc_pkg::LON_LIMIT),
        .TAG_W     (1)
    ) u_deg_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (co_lon_valid),
        .i_angle (co_lon_angle),
        .i_neg   (co_lon_neg),
        .i_tag   (co_lon_tag),
        .o_valid (dg_lon_valid),
        .o_deg   (dg_lon_deg),
        .o_tag   (dg_lon_tag)
    );

    always_comb begin
        lat_ext             = 64'(dg_lat_deg);
        lon_ext             = dg_lon_tag ? '0 : 64'(dg_lon_deg);
        p_result.lat        = lat_ext[elc_pkg::LAT_W-1:0];
        p_result.lon        = lon_ext[elc_pkg::LON_W-1:0];
        p_result.degenerate = dg_lat_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (ce && dg_lat_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out       <= p_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= p_result;
                r_skid_valid <= 1'b1;
            end
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.lon, r_out.lat};
    assign o_m_axis_tuser  = r_out.degenerate;

    a_paths_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dg_lat_valid == dg_lon_valid)
        else $error("latitude and longitude paths out of step");

    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    a_degenerate_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate word with nonzero angles");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ce && dg_lat_valid) |=> dg_lat_valid)
        else $error("pipeline output lost during a stall");

endmodule

[sv/elc_front.sv]
// ----------------------------------------------------------------------------
// elc_front: sort, normalize and form the arctangent operands
// Eight register stages: compare, rank, magnitude, bit length, scaling,
// differences, products and the two radicands.
// ----------------------------------------------------------------------------
module elc_front #(
    parameter int EIG_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  logic                        i_valid,
    input  logic signed [EIG_WIDTH-1:0] i_eig_a,
    input  logic signed [EIG_WIDTH-1:0] i_eig_b,
    input  logic signed [EIG_WIDTH-1:0] i_eig_c,
    output logic                        o_valid,
    output elc_pkg::t_geom              o_geom
);

    localparam int LEN_W = $clog2(EIG_WIDTH + 1);

    logic [8:1] r_valid;

    logic signed [EIG_WIDTH-1:0] r1_a, r1_b, r1_c;
    logic [5:0]                  r1_ge;
    logic                        r1_zero;

    logic signed [EIG_WIDTH-1:0] r2_l1, r2_l2, r2_l3;
    logic                        r2_zero;

    logic signed [EIG_WIDTH-1:0] r3_l1, r3_l2, r3_l3;
    logic [EIG_WIDTH-1:0]        r3_m1, r3_m3;
    logic                        r3_zero;

    logic signed [EIG_WIDTH-1:0] r4_l1, r4_l2, r4_l3;
    logic [LEN_W-1:0]            r4_len;
    logic                        r4_zero;

    logic signed [30:0] r5_n1, r5_n2, r5_n3;
    logic               r5_zero;

    logic [30:0]        r6_a, r6_b, r6_w;
    logic signed [31:0] r6_s, r6_ba;
    logic               r6_zero, r6_lon_zero;

    logic [61:0]        r7_paa, r7_pab, r7_pbb, r7_pww;
    logic signed [31:0] r7_s, r7_ba;
    logic               r7_zero, r7_lon_zero;

    elc_pkg::t_geom r8_geom;

    logic [1:0]                  w_imax, w_imin, w_imid;
    logic [EIG_WIDTH-1:0]        w_mx;
    logic [LEN_W-1:0]            w_len;
    logic [7:0]                  w_len8;
    logic signed [63:0]          w_x1, w_x2, w_x3;
    logic [7:0]                  w_shl, w_shr;
    logic                        w_left;
    logic signed [31:0]          w_e1, w_e2, w_e3;

    function automatic logic signed [EIG_WIDTH-1:0] pick(
        input logic [1:0] idx,
        input logic signed [EIG_WIDTH-1:0] a,
        input logic signed [EIG_WIDTH-1:0] b,
        input logic signed [EIG_WIDTH-1:0] c
    );
        logic signed [EIG_WIDTH-1:0] v;
        case (idx)
            2'd0:    v = a;
            2'd1:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    // r1_ge bits: a>=b, a>=c, b>=c, b>=a, c>=a, c>=b
    always_comb begin
        if (r1_ge[0] && r1_ge[1]) begin
            w_imax = 2'd0;
        end else if (!r1_ge[0] && r1_ge[2]) begin
            w_imax = 2'd1;
        end else begin
            w_imax = 2'd2;
        end
        if (r1_ge[1] && r1_ge[2]) begin
            w_imin = 2'd2;
        end else if (r1_ge[0] && r1_ge[5]) begin
            w_imin = 2'd1;
        end else begin
            w_imin = 2'd0;
        end
        w_imid = 2'd3 - w_imax - w_imin;
    end

    always_comb begin
        w_mx  = (r3_m1 > r3_m3) ? r3_m1 : r3_m3;
        w_len = '0;
        for (int k = 0; k < EIG_WIDTH; k++) begin
            if (w_mx[k]) begin
                w_len = LEN_W'(k + 1);
            end
        end
    end

    always_comb begin
        w_len8 = 8'(r4_len);
        w_left = w_len8 < 8'(elc_pkg::NORM_BITS);
        w_shl  = 8'(elc_pkg::NORM_BITS) - w_len8;
        w_shr  = w_len8 - 8'(elc_pkg::NORM_BITS);
        w_x1   = 64'(r4_l1);
        w_x2   = 64'(r4_l2);
        w_x3   = 64'(r4_l3);
        if (w_left) begin
            w_x1 = w_x1 <<< w_shl;
            w_x2 = w_x2 <<< w_shl;
            w_x3 = w_x3 <<< w_shl;
        end else begin
            w_x1 = w_x1 >>> w_shr;
            w_x2 = w_x2 >>> w_shr;
            w_x3 = w_x3 >>> w_shr;
        end
    end

    always_comb begin
        w_e1 = 32'(r5_n1);
        w_e2 = 32'(r5_n2);
        w_e3 = 32'(r5_n3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_a     <= i_eig_a;
            r1_b     <= i_eig_b;
            r1_c     <= i_eig_c;
            r1_ge    <= {i_eig_c >= i_eig_b, i_eig_c >= i_eig_a, i_eig_b >= i_eig_a,
                         i_eig_b >= i_eig_c, i_eig_a >= i_eig_c, i_eig_a >= i_eig_b};
            r1_zero  <= (i_eig_a == '0) && (i_eig_b == '0) && (i_eig_c == '0);

            r2_l1    <= pick(w_imax, r1_a, r1_b, r1_c);
            r2_l2    <= pick(w_imid, r1_a, r1_b, r1_c);
            r2_l3    <= pick(w_imin, r1_a, r1_b, r1_c);
            r2_zero  <= r1_zero;

            r3_l1    <= r2_l1;
            r3_l2    <= r2_l2;
            r3_l3    <= r2_l3;
            r3_m1    <= r2_l1[EIG_WIDTH-1] ? EIG_WIDTH'(-r2_l1) : EIG_WIDTH'(r2_l1);
            r3_m3    <= r2_l3[EIG_WIDTH-1] ? EIG_WIDTH'(-r2_l3) : EIG_WIDTH'(r2_l3);
            r3_zero  <= r2_zero;

            r4_l1    <= r3_l1;
            r4_l2    <= r3_l2;
            r4_l3    <= r3_l3;
            r4_len   <= w_len;
            r4_zero  <= r3_zero;

            r5_n1    <= w_x1[30:0];
            r5_n2    <= w_x2[30:0];
            r5_n3    <= w_x3[30:0];
            r5_zero  <= r4_zero;

            r6_a        <= 31'(w_e1 - w_e2);
            r6_b        <= 31'(w_e2 - w_e3);
            r6_w        <= 31'(w_e1 - w_e3);
            r6_s        <= w_e1 + w_e2 + w_e3;
            r6_ba       <= (w_e2 - w_e3) - (w_e1 - w_e2);
            r6_zero     <= r5_zero;
            r6_lon_zero <= (w_e1 == w_e3);

            r7_paa      <= 62'(r6_a) * 62'(r6_a);
            r7_pab      <= 62'(r6_a) * 62'(r6_b);
            r7_pbb      <= 62'(r6_b) * 62'(r6_b);
            r7_pww      <= 62'(r6_w) * 62'(r6_w);
            r7_s        <= r6_s;
            r7_ba       <= r6_ba;
            r7_zero     <= r6_zero;
            r7_lon_zero <= r6_lon_zero;

            r8_geom.rad_lat    <= (64'(r7_paa) + 64'(r7_pab) + 64'(r7_pbb)) << 1;
            r8_geom.rad_lon    <= 64'(r7_pww) + (64'(r7_pww) << 1);
            r8_geom.y_lat      <= r7_s;
            r8_geom.y_lon      <= r7_ba;
            r8_geom.degenerate <= r7_zero;
            r8_geom.lon_zero   <= r7_lon_zero;
        end
    end

    assign o_valid = r_valid[8];
    assign o_geom  = r8_geom;

endmodule

[sv/elc_isqrt.sv]
// ----------------------------------------------------------------------------
// elc_isqrt: pipelined integer square root
// Floor of the square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module elc_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  logic [63:0]      i_radicand,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output logic [TAG_W-1:0] o_tag
);

    localparam int STEPS = elc_pkg::ISQRT_STEPS;

    logic             r_valid [0:STEPS-1];
    logic [63:0]      r_rem   [0:STEPS-1];
    logic [63:0]      r_root  [0:STEPS-1];
    logic [TAG_W-1:0] r_tag   [0:STEPS-1];

    genvar j;
    generate
        for (j = 0; j < STEPS; j++) begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
            logic             v_in;
            logic [63:0]      rem_in;
            logic [63:0]      root_in;
            logic [63:0]      trial;
            logic [TAG_W-1:0] tag_in;
            if (j == 0) begin : g_first
                assign v_in    = i_valid;
                assign rem_in  = i_radicand;
                assign root_in = '0;
                assign tag_in  = i_tag;
            end else begin : g_next
                assign v_in    = r_valid[j-1];
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign tag_in  = r_tag[j-1];
            end
            assign trial = root_in + BIT;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else if (i_ce) begin
                    r_valid[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (rem_in >= trial) begin
                        r_rem[j]  <= rem_in - trial;
                        r_root[j] <= (root_in >> 1) + BIT;
                    end else begin
                        r_rem[j]  <= rem_in;
                        r_root[j] <= root_in >> 1;
                    end
                    r_tag[j] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[STEPS-1];
    assign o_root  = r_root[STEPS-1][31:0];
    assign o_tag   = r_tag[STEPS-1];

endmodule

[sv/elc_cordic.sv]
// ----------------------------------------------------------------------------
// elc_cordic: pipelined vectoring arctangent
// An entry stage takes the sign off y, then one rotation per stage gives
// the angle in radians with 48 fraction bits.
// ----------------------------------------------------------------------------
module elc_cordic #(
    parameter int TAG_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  logic [31:0]        i_x,
    input  logic signed [31:0] i_y,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_valid,
    output logic [63:0]        o_angle,
    output logic               o_neg,
    output logic [TAG_W-1:0]   o_tag
);

    localparam int STEPS = elc_pkg::CORDIC_STEPS;

    logic               r_e_valid;
    logic signed [63:0] r_e_x, r_e_y;
    logic               r_e_neg, r_e_zero;
    logic [TAG_W-1:0]   r_e_tag;

    logic               r_valid [0:STEPS-1];
    logic signed [63:0] r_x     [0:STEPS-1];
    logic signed [63:0] r_y     [0:STEPS-1];
    logic signed [63:0] r_z     [0:STEPS-1];
    logic               r_neg   [0:STEPS-1];
    logic               r_zero  [0:STEPS-1];
    logic [TAG_W-1:0]   r_tag   [0:STEPS-1];

    logic [31:0] w_ymag;

    assign w_ymag = i_y[31] ? 32'(-i_y) : 32'(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_ce) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e_x    <= 64'(i_x) << elc_pkg::CORDIC_PRESHIFT;
            r_e_y    <= 64'(w_ymag) << elc_pkg::CORDIC_PRESHIFT;
            r_e_neg  <= i_y[31];
            r_e_zero <= (i_y == '0);
            r_e_tag  <= i_tag;
        end
    end

    genvar j;
    generate
        for (j = 0; j < STEPS; j++) begin : g_step
            localparam logic signed [63:0] ANG = elc_pkg::atan_q48(j);
            logic               v_in, neg_in, zero_in;
            logic signed [63:0] x_in, y_in, z_in;
            logic [TAG_W-1:0]   tag_in;
            if (j == 0) begin : g_first
                assign v_in    = r_e_valid;
                assign x_in    = r_e_x;
                assign y_in    = r_e_y;
                assign z_in    = '0;
                assign neg_in  = r_e_neg;
                assign zero_in = r_e_zero;
                assign tag_in  = r_e_tag;
            end else begin : g_next
                assign v_in    = r_valid[j-1];
                assign x_in    = r_x[j-1];
                assign y_in    = r_y[j-1];
                assign z_in    = r_z[j-1];
                assign neg_in  = r_neg[j-1];
                assign zero_in = r_zero[j-1];
                assign tag_in  = r_tag[j-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else if (i_ce) begin
                    r_valid[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (!y_in[63]) begin
                        r_x[j] <= x_in + (y_in >>> j);
                        r_y[j] <= y_in - (x_in >>> j);
                        r_z[j] <= z_in + ANG;
                    end else begin
                        r_x[j] <= x_in - (y_in >>> j);
                        r_y[j] <= y_in + (x_in >>> j);
                        r_z[j] <= z_in - ANG;
                    end
                    r_neg[j]  <= neg_in;
                    r_zero[j] <= zero_in;
                    r_tag[j]  <= tag_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[STEPS-1];
    assign o_angle = (r_zero[STEPS-1] || r_z[STEPS-1][63]) ? '0 : 64'(r_z[STEPS-1]);
    assign o_neg   = r_neg[STEPS-1];
    assign o_tag   = r_tag[STEPS-1];

endmodule

[sv/elc_degrees.sv]
// ----------------------------------------------------------------------------
// elc_degrees: radians to rounded fixed-point degrees
// Multiplies by 45, divides by pi one quotient bit per stage, then rounds
// half up, saturates at the limit and restores the sign.
// ----------------------------------------------------------------------------
module elc_degrees #(
    parameter int FRAC_BITS = 16,
    parameter int LIMIT_DEG = 90,
    parameter int TAG_W     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  logic                      i_valid,
    input  logic [63:0]               i_angle,
    input  logic                      i_neg,
    input  logic [TAG_W-1:0]          i_tag,
    output logic                      o_valid,
    output logic signed [FRAC_BITS+9:0] o_deg,
    output logic [TAG_W-1:0]          o_tag
);

    localparam int QW    = FRAC_BITS + 9;
    localparam int REM_W = elc_pkg::REM_W;
    localparam logic [REM_W-1:0] DEN = elc_pkg::DEG_DEN[REM_W-1:0];
    localparam logic [QW-1:0]    LIM = QW'(LIMIT_DEG) << FRAC_BITS;

    logic             r_e_valid;
    logic [REM_W-1:0] r_e_rem;
    logic [QW-1:0]    r_e_low;
    logic             r_e_neg;
    logic [TAG_W-1:0] r_e_tag;

    logic             r_valid [0:QW-1];
    logic [REM_W-1:0] r_rem   [0:QW-1];
    logic [QW-1:0]    r_low   [0:QW-1];
    logic [QW-1:0]    r_q     [0:QW-1];
    logic             r_neg   [0:QW-1];
    logic [TAG_W-1:0] r_tag   [0:QW-1];

    logic                  r_f_valid;
    logic signed [QW:0]    r_f_deg;
    logic [TAG_W-1:0]      r_f_tag;

    logic [63:0]   w_num;
    logic [QW:0]   w_round;
    logic [QW-1:0] w_res;

    assign w_num = (i_angle << 5) + (i_angle << 3) + (i_angle << 2) + i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_ce) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e_rem <= w_num[REM_W+7:8];
            r_e_low <= {w_num[7:0], {(FRAC_BITS + 1){1'b0}}};
            r_e_neg <= i_neg;
            r_e_tag <= i_tag;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_step
            logic             v_in, neg_in;
            logic [REM_W-1:0] rem_in, rem_sh;
            logic [QW-1:0]    low_in, q_in;
            logic [TAG_W-1:0] tag_in;
            if (j == 0) begin : g_first
                assign v_in   = r_e_valid;
                assign rem_in = r_e_rem;
                assign low_in = r_e_low;
                assign q_in   = '0;
                assign neg_in = r_e_neg;
                assign tag_in = r_e_tag;
            end else begin : g_next
                assign v_in   = r_valid[j-1];
                assign rem_in = r_rem[j-1];
                assign low_in = r_low[j-1];
                assign q_in   = r_q[j-1];
                assign neg_in = r_neg[j-1];
                assign tag_in = r_tag[j-1];
            end
            assign rem_sh = {rem_in[REM_W-2:0], low_in[QW-1]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else if (i_ce) begin
                    r_valid[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (rem_sh >= DEN) begin
                        r_rem[j] <= rem_sh - DEN;
                        r_q[j]   <= {q_in[QW-2:0], 1'b1};
                    end else begin
                        r_rem[j] <= rem_sh;
                        r_q[j]   <= {q_in[QW-2:0], 1'b0};
                    end
                    r_low[j] <= low_in << 1;
                    r_neg[j] <= neg_in;
                    r_tag[j] <= tag_in;
                end
            end
        end
    endgenerate

    always_comb begin
        w_round = (QW + 1)'(r_q[QW-1]) + 1'b1;
        w_res   = w_round[QW:1];
        if (w_res > LIM) begin
            w_res = LIM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_ce) begin
            r_f_valid <= r_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_f_deg <= r_neg[QW-1] ? -$signed({1'b0, w_res}) : $signed({1'b0, w_res});
            r_f_tag <= r_tag[QW-1];
        end
    end

    assign o_valid = r_f_valid;
    assign o_deg   = r_f_deg;
    assign o_tag   = r_f_tag;

endmodule

[verif/eigenvalues_to_lune_coords_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eigenvalues_to_lune_coords_test: self-checking bench for the lune converter
// Streams eigenvalue triples through the block and computes the expected
// latitude, longitude and degenerate flag for each accepted word, unless
// the directed row gives them; results are compared in arrival order. Both
// sides idle at random, and one long receiver hold-off lets the pipeline fill.
// ----------------------------------------------------------------------------
module eigenvalues_to_lune_coords_test;

    localparam int N_RANDOM = 730;
    localparam longint LAT_FULL = longint'(elc_pkg::LAT_LIMIT) <<< 16;

    typedef struct {
        logic [31:0]      eig_a;
        logic [31:0]      eig_b;
        logic [31:0]      eig_c;
        bit               typed;
        elc_pkg::t_result res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    elc_pkg::t_result pending_angles[$];
    longint           atan_steps[elc_pkg::CORDIC_STEPS];
    int               n_errors;
    int               n_results;
    int               n_degenerate;

    eigenvalues_to_lune_coords dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("%0t: timeout", $time);
        $display("FAIL");
        $finish;
    end

    function automatic void build_atan_steps();
        logic [63:0] acc;
        logic [63:0] term;
        atan_steps[0] = longint'((elc_pkg::PI_Q60 + 64'd8192) >> 14);
        for (int i = 1; i < elc_pkg::CORDIC_STEPS; i++) begin
            acc = '0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            atan_steps[i] = longint'((acc + 64'd8192) >> 14);
        end
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bt;
        r  = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // Arctangent of y over x (x >= 0) in degrees, magnitude capped at limit.
    function automatic longint angle_deg(longint x, longint y, longint limit);
        longint      z;
        longint      dx;
        longint      dy;
        bit          neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] mag;
        z = 0;
        if (y == 0) return 0;
        neg = y < 0;
        if (neg) y = -y;
        x = x <<< 24;
        y = y <<< 24;
        for (int i = 0; i < elc_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_steps[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_steps[i];
            end
        end
        if (z < 0) z = 0;
        num = 64'(z) * 64'd45;
        den = elc_pkg::PI_Q60 >> 14;
        q   = num / den;
        r   = num % den;
        for (int i = 0; i < 17; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        mag = (q + 1) >> 1;
        if (mag > 64'(limit <<< 16)) mag = 64'(limit <<< 16);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic elc_pkg::t_result lune_angles(logic [31:0] ea, logic [31:0] eb,
                                                     logic [31:0] ec);
        longint           hi;
        longint           mid;
        longint           lo;
        longint           t;
        longint           da;
        longint           db;
        longint           sum;
        longint           mx;
        int               len;
        logic [63:0]      ua;
        logic [63:0]      ub;
        logic [63:0]      w;
        elc_pkg::t_result res;
        hi  = longint'($signed(ea));
        mid = longint'($signed(eb));
        lo  = longint'($signed(ec));
        if (hi < mid) begin t = hi; hi = mid; mid = t; end
        if (mid < lo) begin t = mid; mid = lo; lo = t; end
        if (hi < mid) begin t = hi; hi = mid; mid = t; end
        res = '0;
        if (hi == 0 && mid == 0 && lo == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        mx  = (hi < 0 ? -hi : hi);
        if ((lo < 0 ? -lo : lo) > mx) mx = (lo < 0 ? -lo : lo);
        len = 0;
        while (mx != 0) begin
            len++;
            mx = mx >> 1;
        end
        if (len < elc_pkg::NORM_BITS) begin
            hi = hi <<< (elc_pkg::NORM_BITS - len);
            mid = mid <<< (elc_pkg::NORM_BITS - len);
            lo = lo <<< (elc_pkg::NORM_BITS - len);
        end else if (len > elc_pkg::NORM_BITS) begin
            hi = hi >>> (len - elc_pkg::NORM_BITS);
            mid = mid >>> (len - elc_pkg::NORM_BITS);
            lo = lo >>> (len - elc_pkg::NORM_BITS);
        end
        da  = hi - mid;
        db  = mid - lo;
        sum = hi + mid + lo;
        ua  = 64'(da);
        ub  = 64'(db);
        res.lat = elc_pkg::LAT_W'(angle_deg(longint'(root_floor(2 * (ua * ua + ua * ub
                                                                     + ub * ub))),
                                            sum, elc_pkg::LAT_LIMIT));
        if (da + db != 0) begin
            w = ua + ub;
            res.lon = elc_pkg::LON_W'(angle_deg(longint'(root_floor(3 * w * w)), db - da,
                                                elc_pkg::LON_LIMIT));
        end
        return res;
    endfunction

    function automatic logic [31:0] random_eig();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row random_row();
        t_row row;
        row = '{default: '0};
        row.eig_a = random_eig();
        row.eig_b = random_eig();
        row.eig_c = random_eig();
        case ($urandom_range(0, 9))
            0: row.eig_c = row.eig_a;
            1: begin row.eig_b = row.eig_a; row.eig_c = row.eig_a; end
            2: row.eig_b = '0;
            3: row.eig_b = 32'(($signed(row.eig_a) >>> 1) + ($signed(row.eig_c) >>> 1));
            4: row.eig_c = 32'(-$signed(row.eig_a));
            5: begin row.eig_a = '0; row.eig_b = '0; row.eig_c = '0; end
            default: ;
        endcase
        return row;
    endfunction

    // Sender: directed rows first, then random triples, with random gaps.
    task automatic send_word(t_row row);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {row.eig_c, row.eig_b, row.eig_a};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        pending_angles.push_back(row.typed ? row.res
                                           : lune_angles(row.eig_a, row.eig_b, row.eig_c));
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_row directed[$];
        int   wait_cycles;
        build_atan_steps();
        n_errors        = 0;
        n_results       = 0;
        n_degenerate    = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;

        directed.push_back('{32'd0, 32'd0, 32'd0, 1'b1, '{24'd0, 22'd0, 1'b1}});
        directed.push_back('{32'd5, 32'd5, 32'd5, 1'b1,
                             '{elc_pkg::LAT_W'(LAT_FULL), 22'd0, 1'b0}});
        directed.push_back('{-32'sd7, -32'sd7, -32'sd7, 1'b1,
                             '{elc_pkg::LAT_W'(-LAT_FULL), 22'd0, 1'b0}});
        directed.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
                             '{elc_pkg::LAT_W'(-LAT_FULL), 22'd0, 1'b0}});
        directed.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                             '{elc_pkg::LAT_W'(LAT_FULL), 22'd0, 1'b0}});
        directed.push_back('{32'd1, 32'd1, 32'd1, 1'b1,
                             '{elc_pkg::LAT_W'(LAT_FULL), 22'd0, 1'b0}});
        directed.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, '0});
        directed.push_back('{32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b0, '0});
        directed.push_back('{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0});
        directed.push_back('{32'd1, 32'd0, 32'd0, 1'b0, '0});
        directed.push_back('{32'd0, -32'sd1, 32'd0, 1'b0, '0});
        directed.push_back('{32'd1, -32'sd1, 32'd0, 1'b0, '0});
        directed.push_back('{32'd2, -32'sd1, -32'sd1, 1'b0, '0});
        directed.push_back('{32'd1, 32'd1, -32'sd2, 1'b0, '0});
        directed.push_back('{32'd3, 32'd3, 32'd1, 1'b0, '0});
        directed.push_back('{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
        directed.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0});
        directed.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
        directed.push_back('{32'd1000, 32'd999, 32'd998, 1'b0, '0});
        directed.push_back('{32'h1000_0000, 32'd0, 32'h1000_0000, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_word(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) send_word(random_row());
        i_s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_angles.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (150) @(posedge i_clk);
        if (pending_angles.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_angles.size());
            n_errors++;
        end
        $display("Sent %0d triples (%0d directed); checked %0d results, %0d degenerate.",
                 directed.size() + N_RANDOM, directed.size(), n_results, n_degenerate);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once the run is well underway.
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && n_results >= 300) begin
                held  = 1'b1;
                stall = 400;
            end else begin
                stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        elc_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected word tdata=%h tuser=%b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                n_errors++;
            end else begin
                want = pending_angles.pop_front();
                n_results++;
                if (want.degenerate) n_degenerate++;
                if (o_m_axis_tdata[elc_pkg::LAT_W-1:0] !== want.lat) begin
                    $display("%0t: latitude expected %h, got %h",
                             $time, want.lat, o_m_axis_tdata[elc_pkg::LAT_W-1:0]);
                    n_errors++;
                end
                if (o_m_axis_tdata[elc_pkg::LAT_W+elc_pkg::LON_W-1:elc_pkg::LAT_W]
                    !== want.lon) begin
                    $display("%0t: longitude expected %h, got %h", $time, want.lon,
                             o_m_axis_tdata[elc_pkg::LAT_W+elc_pkg::LON_W-1:elc_pkg::LAT_W]);
                    n_errors++;
                end
                if (o_m_axis_tdata[47:elc_pkg::LAT_W+elc_pkg::LON_W] !== '0) begin
                    $display("%0t: padding expected 0, got %b",
                             $time, o_m_axis_tdata[47:elc_pkg::LAT_W+elc_pkg::LON_W]);
                    n_errors++;
                end
                if (o_m_axis_tuser !== want.degenerate) begin
                    $display("%0t: degenerate expected %b, got %b",
                             $time, want.degenerate, o_m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

endmodule
